>>> src/epx_pkg.sv
`default_nettype none

package epx_pkg;

   // Fixed port widths
   localparam int PORT_PIXEL_BITS = 32;
   localparam int COUNT_BITS      = 10;
   localparam int CFG_BITS        = 11;

   // Defaults for the top-level parameters
   localparam int MAX_WIDTH_DEFAULT  = 1024;
   localparam int PIXEL_BITS_DEFAULT = 32;

   // Geometry limits and register reset values
   localparam int WIDTH_LIMIT  = 1024;
   localparam int HEIGHT_LIMIT = 1024;
   localparam logic [CFG_BITS-1:0] WIDTH_RESET  = CFG_BITS'(64);
   localparam logic [CFG_BITS-1:0] HEIGHT_RESET = CFG_BITS'(32);

   // Register indexes
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   // Result queue
   localparam int MAX_RESULTS = 3;
   localparam int PUSH_BITS   = 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [PORT_PIXEL_BITS-1:0] p;
      logic [PORT_PIXEL_BITS-1:0] a;
      logic [PORT_PIXEL_BITS-1:0] b;
      logic [PORT_PIXEL_BITS-1:0] c;
      logic [PORT_PIXEL_BITS-1:0] d;
   } epx_window_type;

   typedef struct packed {
      logic [PORT_PIXEL_BITS-1:0] top_left;
      logic [PORT_PIXEL_BITS-1:0] top_right;
      logic [PORT_PIXEL_BITS-1:0] bottom_left;
      logic [PORT_PIXEL_BITS-1:0] bottom_right;
      logic [COUNT_BITS-1:0]      src_col;
      logic [COUNT_BITS-1:0]      src_row;
      logic                       frame_done;
   } epx_result_type;

   typedef struct packed {
      logic [PUSH_BITS-1:0]                   count;
      epx_result_type [MAX_RESULTS-1:0]       entries;
   } epx_push_type;

   // EPX corner rule on one neighborhood
   function automatic epx_result_type epx_corners(
      input epx_window_type        win,
      input logic [COUNT_BITS-1:0] col,
      input logic [COUNT_BITS-1:0] row,
      input logic                  done
   );
      epx_result_type res;
      res.top_left     = win.p;
      res.top_right    = win.p;
      res.bottom_left  = win.p;
      res.bottom_right = win.p;
      if (win.c == win.a && win.c != win.d && win.a != win.b) res.top_left     = win.a;
      if (win.a == win.b && win.a != win.c && win.b != win.d) res.top_right    = win.b;
      if (win.d == win.c && win.d != win.b && win.c != win.a) res.bottom_left  = win.c;
      if (win.b == win.d && win.b != win.a && win.d != win.c) res.bottom_right = win.d;
      res.src_col    = col;
      res.src_row    = row;
      res.frame_done = done;
      return res;
   endfunction

endpackage

`default_nettype wire

>>> src/epx_pixel_upscaler_2x_unit.sv
`default_nettype none

// Queueing: a block for row y is queued at the edge that accepts pixel (x, y+1);
//   last-row blocks are queued one pixel late, the final one at once.
// Throughput: 1 pixel/cycle on rows but the last while rsp_ready is high; there a pixel
//   makes up to 2 results (3 on the final one), so the single result port stalls input.
// Reset (synchronous): counters, bank, result queue cleared; size back to 64 x 32.
//   The line memory is not cleared and needs no clearing pass.
module epx_pixel_upscaler_2x_unit
   import epx_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEFAULT,
   parameter int PIXEL_BITS = PIXEL_BITS_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // pixel input
   input  wire logic                       req_valid,
   output      logic                       req_ready,
   input  wire logic [PORT_PIXEL_BITS-1:0] req_in_pixel,
   // block output
   output      logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   output      logic [PORT_PIXEL_BITS-1:0] rsp_top_left,
   output      logic [PORT_PIXEL_BITS-1:0] rsp_top_right,
   output      logic [PORT_PIXEL_BITS-1:0] rsp_bottom_left,
   output      logic [PORT_PIXEL_BITS-1:0] rsp_bottom_right,
   output      logic [COUNT_BITS-1:0]      rsp_src_col,
   output      logic [COUNT_BITS-1:0]      rsp_src_row,
   output      logic                       rsp_frame_done,
   // register writes
   input  wire logic                       csr_wr_en,
   input  wire logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [CFG_BITS-1:0]        csr_wr_data
);

   // Line memory: two banks of 2**COL_BITS pixels, bank in the top address bit
   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int ADDR_BITS = COL_BITS + 1;
   localparam int RAM_DEPTH = 2 ** ADDR_BITS;
   localparam int WIDTH_CAP = (MAX_WIDTH < WIDTH_LIMIT) ? MAX_WIDTH : WIDTH_LIMIT;
   localparam logic [CFG_BITS-1:0] WIDTH_CAP_V  = CFG_BITS'(WIDTH_CAP);
   localparam logic [CFG_BITS-1:0] HEIGHT_CAP_V = CFG_BITS'(HEIGHT_LIMIT);

   // Config registers
   logic [CFG_BITS-1:0]   image_width_ff, image_width_in;
   logic [CFG_BITS-1:0]   image_height_ff, image_height_in;

   // Raster position of the next pixel and the bank that receives its row
   logic [COUNT_BITS-1:0] col_ff, col_in;
   logic [COUNT_BITS-1:0] row_ff, row_in;
   logic                  bank_ff, bank_in;

   // Row-above sliding window: C and P for the next pixel (B/A come from the RAM)
   logic [PIXEL_BITS-1:0] win_c_ff, win_p_ff;
   // Last two pixels of the current row
   logic [PIXEL_BITS-1:0] pix_m1_ff, pix_m2_ff;
   // Copies of columns 0 and 1 of each bank, used at the start of a row
   logic [PIXEL_BITS-1:0] b0_col0_ff, b0_col1_ff, b1_col0_ff, b1_col1_ff;

   // RAM read data
   logic [PIXEL_BITS-1:0] rd_above2;   // current bank, column x (row y-2)
   logic [PIXEL_BITS-1:0] rd_right;    // previous bank, column x+1 (row y-1)

   logic [CFG_BITS-1:0]   width_eff, height_eff;
   logic                  last_col, last_row;
   logic                  row_gt0, row_gt1, col_gt0, col_gt1, col_is0, col_is1;
   logic [PIXEL_BITS-1:0] pixel;
   logic [PIXEL_BITS-1:0] up_p, up_a_raw, up_b_raw, up_c, up_a, up_b;
   logic [PIXEL_BITS-1:0] prv_col0, prv_col1, cur_col0;
   logic                  emit_above, emit_left, emit_final;
   logic [PUSH_BITS-1:0]  emit_count;
   epx_window_type        win_above, win_left, win_final;
   epx_result_type        res_above, res_left, res_final;
   epx_push_type          push;
   logic [QCOUNT_BITS-1:0] free_slots;
   epx_result_type        head;
   logic                  accept;
   logic [CFG_BITS-1:0]   col_plus1, col_plus2;
   logic [ADDR_BITS-1:0]  wr_addr, rd_above2_addr, rd_right_addr;

   assign pixel = req_in_pixel[PIXEL_BITS-1:0];

   // --------------------------------------------------------------------
   // Frame geometry: zero acts as one, oversize is clamped
   // --------------------------------------------------------------------
   always_comb begin
      if (image_width_ff == '0) begin
         width_eff = CFG_BITS'(1);
      end else if (image_width_ff > WIDTH_CAP_V) begin
         width_eff = WIDTH_CAP_V;
      end else begin
         width_eff = image_width_ff;
      end
      if (image_height_ff == '0) begin
         height_eff = CFG_BITS'(1);
      end else if (image_height_ff > HEIGHT_CAP_V) begin
         height_eff = HEIGHT_CAP_V;
      end else begin
         height_eff = image_height_ff;
      end
   end

   // A column at or past the last one counts as the last (covers shrinking mid-frame)
   assign last_col = ({1'b0, col_ff} >= (width_eff - CFG_BITS'(1)));
   assign last_row = ({1'b0, row_ff} >= (height_eff - CFG_BITS'(1)));
   assign row_gt0  = (row_ff != '0);
   assign row_gt1  = (row_ff > COUNT_BITS'(1));
   assign col_is0  = (col_ff == '0);
   assign col_is1  = (col_ff == COUNT_BITS'(1));
   assign col_gt0  = !col_is0;
   assign col_gt1  = !col_is0 && !col_is1;

   // --------------------------------------------------------------------
   // Neighborhood of the pixel above. Mid-row it slides: P and C are carried
   // over, B and A were fetched when the previous pixel was taken. At the row
   // start the shadow copies of columns 0/1 stand in for the RAM.
   // --------------------------------------------------------------------
   assign prv_col0 = bank_ff ? b0_col0_ff : b1_col0_ff;
   assign prv_col1 = bank_ff ? b0_col1_ff : b1_col1_ff;
   assign cur_col0 = bank_ff ? b1_col0_ff : b0_col0_ff;

   always_comb begin
      if (col_is0) begin
         up_p     = prv_col0;
         up_c     = prv_col0;
         up_b_raw = prv_col1;
         up_a_raw = cur_col0;
      end else begin
         up_p     = win_p_ff;
         up_c     = win_c_ff;
         up_b_raw = rd_right;
         up_a_raw = rd_above2;
      end
      up_b = last_col ? up_p : up_b_raw;
      up_a = row_gt1 ? up_a_raw : up_p;
   end

   // --------------------------------------------------------------------
   // The three possible blocks for this pixel, in output order:
   //   above  - block (x, y-1), D is the incoming pixel
   //   left   - last row only, block (x-1, y), B is the incoming pixel
   //   final  - last pixel of the frame, block (x, y)
   // --------------------------------------------------------------------
   always_comb begin
      win_above.p = PORT_PIXEL_BITS'(up_p);
      win_above.a = PORT_PIXEL_BITS'(up_a);
      win_above.b = PORT_PIXEL_BITS'(up_b);
      win_above.c = PORT_PIXEL_BITS'(up_c);
      win_above.d = PORT_PIXEL_BITS'(pixel);

      win_left.p = PORT_PIXEL_BITS'(pix_m1_ff);
      win_left.a = row_gt0 ? PORT_PIXEL_BITS'(up_c) : PORT_PIXEL_BITS'(pix_m1_ff);
      win_left.b = PORT_PIXEL_BITS'(pixel);
      win_left.c = col_gt1 ? PORT_PIXEL_BITS'(pix_m2_ff) : PORT_PIXEL_BITS'(pix_m1_ff);
      win_left.d = PORT_PIXEL_BITS'(pix_m1_ff);

      win_final.p = PORT_PIXEL_BITS'(pixel);
      win_final.a = row_gt0 ? PORT_PIXEL_BITS'(up_p) : PORT_PIXEL_BITS'(pixel);
      win_final.b = PORT_PIXEL_BITS'(pixel);
      win_final.c = col_gt0 ? PORT_PIXEL_BITS'(pix_m1_ff) : PORT_PIXEL_BITS'(pixel);
      win_final.d = PORT_PIXEL_BITS'(pixel);
   end

   assign res_above = epx_corners(win_above, col_ff, row_ff - COUNT_BITS'(1), 1'b0);
   assign res_left  = epx_corners(win_left, col_ff - COUNT_BITS'(1), row_ff, 1'b0);
   assign res_final = epx_corners(win_final, col_ff, row_ff, 1'b1);

   assign emit_above = row_gt0;
   assign emit_left  = last_row && col_gt0;
   assign emit_final = last_row && last_col;
   assign emit_count = PUSH_BITS'(emit_above) + PUSH_BITS'(emit_left)
                     + PUSH_BITS'(emit_final);

   // Take a pixel only when the queue has room for everything it makes
   assign req_ready = (QCOUNT_BITS'(emit_count) <= free_slots);
   assign accept    = req_valid && req_ready;

   // Pack the valid results into consecutive queue slots
   always_comb begin
      push.count = accept ? emit_count : '0;
      if (emit_above) begin
         push.entries[0] = res_above;
      end else if (emit_left) begin
         push.entries[0] = res_left;
      end else begin
         push.entries[0] = res_final;
      end
      push.entries[1] = (emit_above && emit_left) ? res_left : res_final;
      push.entries[2] = res_final;
   end

   epx_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .free_slots (free_slots),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .head       (head)
   );

   assign rsp_top_left     = head.top_left;
   assign rsp_top_right    = head.top_right;
   assign rsp_bottom_left  = head.bottom_left;
   assign rsp_bottom_right = head.bottom_right;
   assign rsp_src_col      = head.src_col;
   assign rsp_src_row      = head.src_row;
   assign rsp_frame_done   = head.frame_done;

   // --------------------------------------------------------------------
   // Line memory. Each accepted pixel writes its own column of the current
   // bank and prefetches what the next pixel needs: column x+1 of the current
   // bank (still row y-2) and column x+2 of the previous bank. The read data
   // holds until the next transaction, so input gaps are harmless. Reads past
   // the row end only feed values that are discarded.
   // --------------------------------------------------------------------
   assign col_plus1      = {1'b0, col_ff} + CFG_BITS'(1);
   assign col_plus2      = {1'b0, col_ff} + CFG_BITS'(2);
   assign wr_addr        = {bank_ff, COL_BITS'(col_ff)};
   assign rd_above2_addr = {bank_ff, COL_BITS'(col_plus1)};
   assign rd_right_addr  = {!bank_ff, COL_BITS'(col_plus2)};

   epx_ram_2r1w #(
      .DATA_BITS (PIXEL_BITS),
      .DEPTH     (RAM_DEPTH)
   ) u_line_ram (
      .clock     (clock),
      .wr_en     (accept),
      .wr_addr   (wr_addr),
      .wr_data   (pixel),
      .rd_a_en   (accept),
      .rd_a_addr (rd_above2_addr),
      .rd_a_data (rd_above2),
      .rd_b_en   (accept),
      .rd_b_addr (rd_right_addr),
      .rd_b_data (rd_right)
   );

   // --------------------------------------------------------------------
   // Position and config next state
   // --------------------------------------------------------------------
   always_comb begin
      col_in          = col_ff;
      row_in          = row_ff;
      bank_in         = bank_ff;
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      if (accept) begin
         if (last_col) begin
            col_in  = '0;
            row_in  = last_row ? '0 : row_ff + COUNT_BITS'(1);
            bank_in = !bank_ff;
         end else begin
            col_in = col_ff + COUNT_BITS'(1);
         end
      end
      if (csr_wr_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  image_width_in  = csr_wr_data;
            CSR_IMAGE_HEIGHT: image_height_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff          <= '0;
         row_ff          <= '0;
         bank_ff         <= 1'b0;
         image_width_ff  <= WIDTH_RESET;
         image_height_ff <= HEIGHT_RESET;
      end else begin
         col_ff          <= col_in;
         row_ff          <= row_in;
         bank_ff         <= bank_in;
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
      end
   end

   // Window, row history and column 0/1 shadows: payload only
   always_ff @(posedge clock) begin
      if (accept) begin
         win_c_ff  <= up_p;
         win_p_ff  <= up_b_raw;
         pix_m2_ff <= pix_m1_ff;
         pix_m1_ff <= pixel;
         if (col_is0 && !bank_ff) begin
            b0_col0_ff <= pixel;
         end
         if (col_is0 && bank_ff) begin
            b1_col0_ff <= pixel;
         end
         if (col_is1 && !bank_ff) begin
            b0_col1_ff <= pixel;
         end
         if (col_is1 && bank_ff) begin
            b1_col1_ff <= pixel;
         end
      end
   end

endmodule

`default_nettype wire

>>> src/epx_ram_2r1w.sv
`default_nettype none

// Generic RAM: one write port, two registered read ports
module epx_ram_2r1w #(
   parameter int DATA_BITS = 32,
   parameter int DEPTH     = 2048
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [DATA_BITS-1:0]       wr_data,
   input  wire logic                       rd_a_en,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_a_addr,
   output      logic [DATA_BITS-1:0]       rd_a_data,
   input  wire logic                       rd_b_en,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_b_addr,
   output      logic [DATA_BITS-1:0]       rd_b_data
);

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_a_data_ff;
   logic [DATA_BITS-1:0] rd_b_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_a_en) begin
         rd_a_data_ff <= mem[rd_a_addr];
      end
      if (rd_b_en) begin
         rd_b_data_ff <= mem[rd_b_addr];
      end
   end

   assign rd_a_data = rd_a_data_ff;
   assign rd_b_data = rd_b_data_ff;

endmodule

`default_nettype wire

>>> src/epx_rsp_queue.sv
`default_nettype none

// Result queue: up to three pushes per cycle, one pop
module epx_rsp_queue
   import epx_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire epx_push_type           push,
   output      logic [QCOUNT_BITS-1:0] free_slots,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      epx_result_type         head
);

   epx_result_type         entries_ff [QUEUE_DEPTH];
   epx_result_type         entries_in [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_BITS-1:0] count_ff, count_in;
   logic                   pop;

   assign rsp_valid  = (count_ff != '0);
   assign pop        = rsp_valid && rsp_ready;
   assign free_slots = QCOUNT_BITS'(QUEUE_DEPTH) - count_ff;
   assign head       = entries_ff[rd_ptr_ff];

   always_comb begin
      entries_in = entries_ff;
      for (int k = 0; k < MAX_RESULTS; k++) begin
         if (PUSH_BITS'(k) < push.count) begin
            entries_in[wr_ptr_ff + QPTR_BITS'(k)] = push.entries[k];
         end
      end
      wr_ptr_in = wr_ptr_ff + QPTR_BITS'(push.count);
      rd_ptr_in = rd_ptr_ff + QPTR_BITS'(pop);
      count_in  = count_ff + QCOUNT_BITS'(push.count) - QCOUNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
   end

endmodule

`default_nettype wire
